// ===== hdl/c4a50_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c4a50_pkg
// Shared types and constants of the 4A50 bank mapper.
// ----------------------------------------------------------------------------
package c4a50_pkg;

  localparam int unsigned RomAw = 17;
  localparam int unsigned RamAw = 15;
  localparam int unsigned RomBytes = 1 << RomAw;
  localparam int unsigned RamBytes = 1 << RamAw;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TGT_CART     = 2'd0,
    TGT_RIOT     = 2'd1,
    TGT_TIA      = 2'd2,
    TGT_UNMAPPED = 2'd3
  } target_e;

  // Bank numbers as stored: low and middle offsets are bank * 2K, high is bank * 256.
  typedef struct packed {
    logic [4:0] low_bank;
    logic [4:0] mid_bank;
    logic [7:0] high_bank;
    logic [2:0] is_rom;  // bit0 low, bit1 middle, bit2 high
  } map_t;

  localparam map_t MapReset = '{low_bank: 5'd0, mid_bank: 5'd0, high_bank: 8'd0,
                                is_rom: 3'b111};

  // One bus access as seen by the bank registers.
  typedef struct packed {
    logic        valid;
    logic        is_read;
    logic [12:0] address;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    map_t map;
    logic changed;
  } bank_stat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] target;
    logic       changed;
  } word_t;

  localparam logic [7:0]  GateMask      = 8'he0;
  localparam logic [7:0]  GateMatch     = 8'h60;
  localparam logic [7:0]  PrevDataReset = 8'hff;
  localparam logic [12:0] PrevAddrReset = 13'h1fff;
  localparam logic [8:0]  TopPageRom    = 9'h1ff;

endpackage

// ===== hdl/c4a50_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c4a50_in_if
// Bus access channel: valid/ready with access kind, address, data, ROM index.
// ----------------------------------------------------------------------------
interface c4a50_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] address;
  logic [7:0]  bus_data;
  logic [16:0] rom_index;

  modport source (output valid, kind, address, bus_data, rom_index, input ready);
  modport sink (input valid, kind, address, bus_data, rom_index, output ready);
endinterface

// ===== hdl/c4a50_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c4a50_out_if
// Result channel: valid/ready with read data, target and bank-changed flag.
// ----------------------------------------------------------------------------
interface c4a50_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] target;
  logic       bank_changed;

  modport source (output valid, read_data, target, bank_changed, input ready);
  modport sink (input valid, read_data, target, bank_changed, output ready);
endinterface

// ===== hdl/c4a50_bank_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c4a50_bank_regs
// Window mapping registers, hotspot decode and the previous-access gate.
// ----------------------------------------------------------------------------
module c4a50_bank_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  c4a50_pkg::access_t     acc_i,
  input  logic [7:0]             mem_rdata_i,
  output c4a50_pkg::bank_stat_t  stat_o
);

  c4a50_pkg::map_t map_q, map_d;
  logic            lock_q;
  logic [7:0]      prev_data_q;
  logic [12:0]     prev_addr_q;
  logic            prev_mem_q;
  logic [7:0]      prev_data;
  logic            gate;
  logic            unmapped;
  logic [7:0]      v;
  logic [12:0]     a;
  logic            changed;

  assign a         = acc_i.address;
  assign unmapped  = !a[7] && a[9];
  assign v         = (acc_i.is_read && unmapped) ? 8'd0 : acc_i.data;
  // A cartridge read leaves its data in the memory output register.
  assign prev_data = prev_mem_q ? mem_rdata_i : prev_data_q;
  assign gate      = ((prev_data & c4a50_pkg::GateMask) == c4a50_pkg::GateMatch) &&
                     (prev_addr_q[12] || (prev_addr_q[12:9] == 4'd0));

  always_comb begin
    map_d   = map_q;
    changed = 1'b0;
    if (acc_i.valid && !lock_q) begin
      if (!a[12]) begin
        priority if (gate && a[11:8] == 4'hc) begin
          map_d.high_bank = a[7:0];
          map_d.is_rom[2] = 1'b1;
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'hd) begin
          map_d.high_bank = {1'b0, a[6:0]};
          map_d.is_rom[2] = 1'b0;
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'he && !a[6]) begin
          map_d.low_bank  = a[4:0];
          map_d.is_rom[0] = 1'b1;
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'he && a[6]) begin
          map_d.low_bank  = {1'b0, a[3:0]};
          map_d.is_rom[0] = 1'b0;
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'hf && !a[6]) begin
          map_d.mid_bank  = a[4:0];
          map_d.is_rom[1] = 1'b1;
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'hf && a[6] && !a[4]) begin
          map_d.mid_bank  = {1'b0, a[3:0]};
          map_d.is_rom[1] = 1'b0;
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'h4) begin
          map_d.low_bank[0] = !map_q.low_bank[0];
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'h5) begin
          map_d.low_bank[1] = !map_q.low_bank[1];
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'h8) begin
          map_d.mid_bank[0] = !map_q.mid_bank[0];
          changed = 1'b1;
        end else if (gate && a[11:8] == 4'h9) begin
          map_d.mid_bank[1] = !map_q.mid_bank[1];
          changed = 1'b1;
        end else if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2] && !a[0]) begin
          map_d.high_bank = v;
          map_d.is_rom[2] = 1'b1;
          changed = 1'b1;
        end else if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2] && a[0]) begin
          map_d.high_bank = {1'b0, v[6:0]};
          map_d.is_rom[2] = 1'b0;
          changed = 1'b1;
        end else if (a[11:8] == 4'h0 && a[6:2] == 5'b11110) begin
          // Data-driven select: upper nibble picks window and source.
          priority if (v[7:4] == 4'h0) begin
            map_d.low_bank  = {1'b0, v[3:0]};
            map_d.is_rom[0] = 1'b1;
            changed = 1'b1;
          end else if (v[7:4] == 4'h4) begin
            map_d.low_bank  = {1'b0, v[3:0]};
            map_d.is_rom[0] = 1'b0;
            changed = 1'b1;
          end else if (v[7:4] == 4'h9) begin
            map_d.mid_bank  = {1'b1, v[3:0]};
            map_d.is_rom[1] = 1'b1;
            changed = 1'b1;
          end else if (v[7:4] == 4'hc) begin
            map_d.mid_bank  = {1'b0, v[3:0]};
            map_d.is_rom[1] = 1'b0;
            changed = 1'b1;
          end else begin
            changed = 1'b0;
          end
        end else begin
          changed = 1'b0;
        end
      end else if (a[12:8] == 5'h1f && gate) begin
        map_d.high_bank[3:0] = {a[3], a[6:4]};
        changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= c4a50_pkg::MapReset;
      lock_q      <= 1'b0;
      prev_data_q <= c4a50_pkg::PrevDataReset;
      prev_addr_q <= c4a50_pkg::PrevAddrReset;
      prev_mem_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lock_q <= cfg_wdata_i;
      end
      if (acc_i.valid) begin
        map_q       <= map_d;
        prev_data_q <= v;
        prev_addr_q <= a;
        prev_mem_q  <= acc_i.is_read && a[12];
      end
    end
  end

  assign stat_o.map     = map_q;
  assign stat_o.changed = changed;

endmodule

// ===== hdl/cartridge_4a50_bank_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_4a50_bank_mapper
// Maps CPU bus accesses onto a 128K ROM image and a 32K RAM for the 4A50 scheme.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                 handshake
//  in_i     in   kind, address, bus_data, rom_index      valid/ready
//  out_o    out  read_data, target, bank_changed         valid/ready
//  cfg      in   cfg_wdata_i (hotspots_locked)           cfg_we_i
//
// One access per cycle while in_i.ready is high; a result passes through the memory
// read register, then the result queue, after its access is taken.
// Reset clears mapping and gate state; ROM and RAM contents are not cleared.
// A three-word result queue absorbs output stalls; in_i.ready drops only when
// the queue plus the word in flight already hold three words.
module cartridge_4a50_bank_mapper (
  input  logic      clk_i,
  input  logic      rst_ni,
  c4a50_in_if.sink  in_i,
  c4a50_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam int unsigned QDepth = 3;

  typedef struct packed {
    logic       from_mem;
    logic [7:0] value;
    logic [1:0] target;
    logic       changed;
  } stage_t;

  logic                   in_accept;
  c4a50_pkg::kind_e       kind;
  logic                   is_rw;
  logic                   is_read;
  logic [12:0]            a;
  logic                   win_low_lo;
  logic                   win_lo;
  logic                   win_mid;
  logic                   win_high;
  logic                   win_top;
  c4a50_pkg::target_e     low_target;
  c4a50_pkg::access_t     acc;
  c4a50_pkg::bank_stat_t  bank_stat;
  logic                   window_rom;
  logic [c4a50_pkg::RomAw-1:0] rom_raddr;
  logic [c4a50_pkg::RamAw-1:0] ram_addr;
  logic                   rom_re;
  logic                   rom_we;
  logic                   ram_re;
  logic                   ram_we;

  logic [7:0] rom_mem [c4a50_pkg::RomBytes];
  logic [7:0] ram_mem [c4a50_pkg::RamBytes];
  logic [7:0] rom_q;
  logic [7:0] ram_q;
  logic       mem_sel_q;  // 1: last read came from ROM
  logic [7:0] mem_rdata;

  stage_t s1_q, s1_d;
  logic   s1_valid_q;

  c4a50_pkg::word_t q_mem [QDepth];
  logic [1:0] wr_ptr_q;
  logic [1:0] rd_ptr_q;
  logic [1:0] q_count_q;
  logic       push;
  logic       pop;
  c4a50_pkg::word_t push_word;

  assign in_accept = in_i.valid && in_i.ready;
  assign kind      = c4a50_pkg::kind_e'(in_i.kind);
  assign a         = in_i.address;
  assign is_read   = (kind == c4a50_pkg::KIND_READ);
  assign is_rw     = (kind == c4a50_pkg::KIND_READ) || (kind == c4a50_pkg::KIND_WRITE);

  // Window decode.
  assign win_low_lo = !a[12];
  assign win_lo     = a[12:11] == 2'b10;
  assign win_mid    = a[12:11] == 2'b11 && a[10:9] != 2'b11;
  assign win_high   = a[12:8] == 5'h1e;
  assign win_top    = a[12:8] == 5'h1f;

  always_comb begin
    priority if (a[7]) begin
      low_target = c4a50_pkg::TGT_RIOT;
    end else if (!a[9]) begin
      low_target = c4a50_pkg::TGT_TIA;
    end else begin
      low_target = c4a50_pkg::TGT_UNMAPPED;
    end
  end

  assign acc.valid   = in_accept && is_rw;
  assign acc.is_read = is_read;
  assign acc.address = a;
  assign acc.data    = in_i.bus_data;

  c4a50_bank_regs u_bank_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .mem_rdata_i (mem_rdata),
    .stat_o      (bank_stat)
  );

  // Offsets are bank multiples, so indexes are plain concatenations.
  always_comb begin
    window_rom = 1'b1;
    rom_raddr  = {c4a50_pkg::TopPageRom, a[7:0]};
    ram_addr   = {bank_stat.map.low_bank[3:0], a[10:0]};
    priority if (win_lo) begin
      window_rom = bank_stat.map.is_rom[0];
      rom_raddr  = {1'b0, bank_stat.map.low_bank, a[10:0]};
      ram_addr   = {bank_stat.map.low_bank[3:0], a[10:0]};
    end else if (win_mid) begin
      window_rom = bank_stat.map.is_rom[1];
      rom_raddr  = {1'b1, bank_stat.map.mid_bank, a[10:0]};
      ram_addr   = {bank_stat.map.mid_bank[3:0], a[10:0]};
    end else if (win_high) begin
      window_rom = bank_stat.map.is_rom[2];
      rom_raddr  = {1'b1, bank_stat.map.high_bank, a[7:0]};
      ram_addr   = {bank_stat.map.high_bank[6:0], a[7:0]};
    end else begin
      window_rom = 1'b1;
    end
  end

  assign rom_re = in_accept && is_read && a[12] && (window_rom || win_top);
  assign ram_re = in_accept && is_read && a[12] && !window_rom && !win_top;
  assign ram_we = in_accept && (kind == c4a50_pkg::KIND_WRITE) && a[12] &&
                  !win_top && !window_rom;
  assign rom_we = in_accept && (kind == c4a50_pkg::KIND_LOAD);

  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      rom_mem[in_i.rom_index] <= in_i.bus_data;
    end
    if (rom_re) begin
      rom_q <= rom_mem[rom_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_addr] <= in_i.bus_data;
    end
    if (ram_re) begin
      ram_q <= ram_mem[ram_addr];
    end
  end

  assign mem_rdata = mem_sel_q ? rom_q : ram_q;

  always_comb begin
    s1_d = '0;
    if (is_rw) begin
      s1_d.changed = bank_stat.changed || ram_we;
      if (win_low_lo) begin
        s1_d.target = low_target;
        if (is_read && low_target != c4a50_pkg::TGT_UNMAPPED) begin
          s1_d.value = in_i.bus_data;
        end
      end else begin
        s1_d.target   = c4a50_pkg::TGT_CART;
        s1_d.from_mem = is_read;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mem_sel_q  <= 1'b1;
    end else begin
      s1_valid_q <= in_accept;
      if (rom_re || ram_re) begin
        mem_sel_q <= rom_re;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Result queue.
  assign push                = s1_valid_q;
  assign pop                 = out_o.valid && out_o.ready;
  assign push_word.read_data = s1_q.from_mem ? mem_rdata : s1_q.value;
  assign push_word.target    = s1_q.target;
  assign push_word.changed   = s1_q.changed;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 2'd0;
      rd_ptr_q  <= 2'd0;
      q_count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == 2'(QDepth - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'(QDepth - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      q_count_q <= q_count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Take a word only when the queue can hold it and the one in flight.
  assign in_i.ready = ({1'b0, q_count_q} + {2'b00, s1_valid_q}) <= 3'(QDepth - 1);

  assign out_o.valid        = q_count_q != 2'd0;
  assign out_o.read_data    = q_mem[rd_ptr_q].read_data;
  assign out_o.target       = q_mem[rd_ptr_q].target;
  assign out_o.bank_changed = q_mem[rd_ptr_q].changed;

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> q_count_q != 2'(QDepth))
    else $error("result queue full while a word is in flight");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> out_o.valid)
    else $error("pushed word not visible at output");

  a_map_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(bank_stat.map))
    else $error("mapping changed without an accepted access");

endmodule

// ===== sim/cartridge_4a50_bank_mapper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_4a50_bank_mapper_tb
// Feeds bus reads, writes and ROM image loads into the 4A50 mapper with random
// gaps and output stalls, and checks every result word against an in-bench
// model of the bank registers, the hotspot gate, the ROM image and the RAM.
// ----------------------------------------------------------------------------
module cartridge_4a50_bank_mapper_tb;

  localparam int CycleLimit   = 400000;
  localparam int RomUpperHalf = 'h10000;
  localparam int TopPageBase  = {c4a50_pkg::TopPageRom, 8'h00};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  c4a50_in_if  acc_if ();
  c4a50_out_if res_if ();

  cartridge_4a50_bank_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (acc_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mapper model state
  logic [7:0]  rom_img [0:c4a50_pkg::RomBytes-1];
  bit          rom_known [0:c4a50_pkg::RomBytes-1];
  logic [7:0]  ram_img [0:c4a50_pkg::RamBytes-1];
  bit          ram_known [0:c4a50_pkg::RamBytes-1];
  logic [15:0] low_ofs   = '0;
  logic [15:0] mid_ofs   = '0;
  logic [15:0] high_ofs  = '0;
  logic [2:0]  win_rom   = 3'b111;
  logic [7:0]  last_data = c4a50_pkg::PrevDataReset;
  logic [12:0] last_addr = c4a50_pkg::PrevAddrReset;
  bit          hot_lock  = 1'b0;
  bit          bank_hit;

  c4a50_pkg::word_t pending_words[$];

  int  items_sent;
  int  words_checked;
  int  changes_seen;
  int  lock_writes;
  int  mismatches;
  int  drain_hold;
  bit  steady_feed;
  bit  steady_drain;

  function automatic bit gate_open();
    return ((last_data & c4a50_pkg::GateMask) == c4a50_pkg::GateMatch) &&
           (last_addr >= 13'h1000 || last_addr < 13'h0200);
  endfunction

  function automatic void sel_low(bit rom, logic [4:0] bank);
    low_ofs    = {bank, 11'b0};
    win_rom[0] = rom;
    bank_hit   = 1'b1;
  endfunction

  function automatic void sel_mid(bit rom, logic [4:0] bank);
    mid_ofs    = {bank, 11'b0};
    win_rom[1] = rom;
    bank_hit   = 1'b1;
  endfunction

  function automatic void sel_high(bit rom, logic [7:0] bank);
    high_ofs   = {bank, 8'b0};
    win_rom[2] = rom;
    bank_hit   = 1'b1;
  endfunction

  // Store entry behind a cartridge-space address under the current mapping.
  function automatic bit store_slot(input logic [12:0] a, output bit from_rom,
                                    output int idx);
    int raw;
    from_rom = 1'b1;
    idx = 0;
    if (!a[12]) return 1'b0;
    if (!a[11]) begin
      from_rom = win_rom[0];
      raw = a[10:0] + low_ofs;
    end else if (a <= 13'h1dff) begin
      from_rom = win_rom[1];
      raw = a[10:0] + mid_ofs + (from_rom ? RomUpperHalf : 0);
    end else if (a[12:8] == 5'h1e) begin
      from_rom = win_rom[2];
      raw = a[7:0] + high_ofs + (from_rom ? RomUpperHalf : 0);
    end else begin
      raw = TopPageBase + a[7:0];
    end
    idx = from_rom ? raw % int'(c4a50_pkg::RomBytes) : raw % int'(c4a50_pkg::RamBytes);
    return 1'b1;
  endfunction

  function automatic void low_hotspots(logic [12:0] a, logic [7:0] v);
    if (hot_lock) return;
    if (gate_open()) begin
      if (a[11:8] == 4'hc) sel_high(1'b1, a[7:0]);
      else if (a[11:8] == 4'hd) sel_high(1'b0, {1'b0, a[6:0]});
      else if (a[11:8] == 4'he && !a[6]) sel_low(1'b1, a[4:0]);
      else if (a[11:8] == 4'he) sel_low(1'b0, {1'b0, a[3:0]});
      else if (a[11:8] == 4'hf && !a[6]) sel_mid(1'b1, a[4:0]);
      else if (a[11:8] == 4'hf && !a[4]) sel_mid(1'b0, {1'b0, a[3:0]});
      else if (a[11:8] == 4'h4) begin low_ofs ^= 16'h0800; bank_hit = 1'b1; end
      else if (a[11:8] == 4'h5) begin low_ofs ^= 16'h1000; bank_hit = 1'b1; end
      else if (a[11:8] == 4'h8) begin mid_ofs ^= 16'h0800; bank_hit = 1'b1; end
      else if (a[11:8] == 4'h9) begin mid_ofs ^= 16'h1000; bank_hit = 1'b1; end
    end
    // zero-page selects take the bank from the data byte and need no gate
    if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2]) begin
      if (!a[0]) sel_high(1'b1, v);
      else sel_high(1'b0, {1'b0, v[6:0]});
    end else if (a[11:8] == 4'h0 && a[6:2] == 5'b11110) begin
      case (v[7:4])
        4'h0: sel_low(1'b1, {1'b0, v[3:0]});
        4'h4: sel_low(1'b0, {1'b0, v[3:0]});
        4'h9: sel_mid(1'b1, {1'b1, v[3:0]});
        4'hc: sel_mid(1'b0, {1'b0, v[3:0]});
        default: ;
      endcase
    end
  endfunction

  function automatic c4a50_pkg::word_t map_access(c4a50_pkg::kind_e k, logic [12:0] a,
                                                  logic [7:0] d, logic [16:0] ri);
    c4a50_pkg::word_t w;
    bit               rd;
    bit               from_rom;
    int               idx;
    logic [7:0]       v;
    w = '0;
    bank_hit = 1'b0;
    case (k)
      c4a50_pkg::KIND_LOAD: begin
        rom_img[ri]   = d;
        rom_known[ri] = 1'b1;
      end
      c4a50_pkg::KIND_READ, c4a50_pkg::KIND_WRITE: begin
        rd = (k == c4a50_pkg::KIND_READ);
        v = '0;
        if (!a[12]) begin
          if (a[7]) w.target = c4a50_pkg::TGT_RIOT;
          else if (!a[9]) w.target = c4a50_pkg::TGT_TIA;
          else w.target = c4a50_pkg::TGT_UNMAPPED;
          if (rd && w.target != c4a50_pkg::TGT_UNMAPPED) v = d;
          low_hotspots(a, rd ? v : d);
        end else begin
          void'(store_slot(a, from_rom, idx));
          if (rd) begin
            v = from_rom ? rom_img[idx] : ram_img[idx];
          end else if (!from_rom) begin
            ram_img[idx]   = d;
            ram_known[idx] = 1'b1;
            bank_hit       = 1'b1;
          end
          if (a[12:8] == 5'h1f && !hot_lock && gate_open()) begin
            high_ofs = {high_ofs[15:12], a[3], a[6:4], high_ofs[7:0]};
            bank_hit = 1'b1;
          end
        end
        last_data = rd ? v : d;
        last_addr = a;
        if (rd) w.read_data = v;
      end
      default: ;
    endcase
    w.changed = bank_hit;
    return w;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: MISMATCH %s", $time, what);
  endfunction

  // Result side: random stalls per word, with stretches of none
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) steady_drain = !steady_drain;
      if (res_if.valid && res_if.ready) drain_hold = steady_drain ? 0 : $urandom_range(0, 3);
      if (drain_hold > 0) begin
        res_if.ready <= 1'b0;
        drain_hold--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    c4a50_pkg::word_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_words.size() == 0) begin
        note_mismatch("result word with nothing pending");
      end else begin
        want = pending_words.pop_front();
        if (res_if.read_data !== want.read_data || res_if.target !== want.target ||
            res_if.bank_changed !== want.changed) begin
          note_mismatch($sformatf(
            "word %0d: expected data %02h target %0d changed %0b, got %02h %0d %0b",
            words_checked, want.read_data, want.target, want.changed,
            res_if.read_data, res_if.target, res_if.bank_changed));
        end
      end
      words_checked++;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout: %0d words still pending", pending_words.size());
    $display("cartridge_4a50_bank_mapper_tb: errors");
    $finish;
  end

  // Call at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input c4a50_pkg::kind_e k, input logic [12:0] a,
                           input logic [7:0] d, input logic [16:0] ri);
    int               gap;
    c4a50_pkg::word_t w;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      acc_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    acc_if.valid     <= 1'b1;
    acc_if.kind      <= k;
    acc_if.address   <= a;
    acc_if.bus_data  <= d;
    acc_if.rom_index <= ri;
    do @(posedge clk_i); while (!acc_if.ready);
    w = map_access(k, a, d, ri);
    pending_words.push_back(w);
    items_sent++;
    if (w.changed) changes_seen++;
  endtask

  // Reads never touch a store entry that was not written: fill it first.
  task automatic bus_access(input c4a50_pkg::kind_e k, input logic [12:0] a,
                            input logic [7:0] d, input logic [16:0] ri);
    bit from_rom;
    int idx;
    if (k == c4a50_pkg::KIND_READ && store_slot(a, from_rom, idx)) begin
      if (from_rom && !rom_known[idx]) begin
        send_word(c4a50_pkg::KIND_LOAD, a, 8'($urandom), 17'(idx));
      end else if (!from_rom && !ram_known[idx]) begin
        send_word(c4a50_pkg::KIND_WRITE, a, 8'($urandom), ri);
      end
    end
    send_word(k, a, d, ri);
  endtask

  task automatic finish_traffic();
    acc_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lock(input bit v);
    finish_traffic();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    hot_lock = v;
    lock_writes++;
  endtask

  // Leave a data byte of 011xxxxx from a gate-opening address, or break one of the two.
  task automatic open_gate(input bit broken);
    logic [12:0]      a;
    logic [7:0]       d;
    c4a50_pkg::kind_e k;
    d = {3'b011, 5'($urandom)};
    if ($urandom_range(0, 1) == 1) begin
      a = {1'b1, 12'($urandom)};
      k = c4a50_pkg::KIND_WRITE;
    end else begin
      a = {4'b0, 9'($urandom)};
      k = c4a50_pkg::kind_e'($urandom_range(0, 1));
    end
    if (broken) begin
      if ($urandom_range(0, 1) == 1) d[7] = 1'b1;
      else a = {1'b0, 3'($urandom_range(1, 7)), 9'($urandom)};
    end
    bus_access(k, a, d, 17'($urandom));
  endtask

  function automatic logic [12:0] hotspot_addr();
    logic [3:0] nib;
    case ($urandom_range(0, 8))
      0: nib = 4'h4;
      1: nib = 4'h5;
      2: nib = 4'h8;
      3: nib = 4'h9;
      4: nib = 4'hc;
      5: nib = 4'hd;
      6: nib = 4'he;
      7: nib = 4'hf;
      default: nib = 4'($urandom);
    endcase
    return {1'b0, nib, 8'($urandom)};
  endfunction

  function automatic logic [12:0] zero_page_addr();
    if ($urandom_range(0, 1) == 1)
      return {1'b0, 4'h0, 1'($urandom), 3'b111, 1'($urandom), 1'b1, 1'($urandom),
              1'($urandom)};
    return {1'b0, 4'h0, 1'($urandom), 5'b11110, 2'($urandom)};
  endfunction

  function automatic logic [7:0] zero_page_data();
    logic [3:0] nib;
    case ($urandom_range(0, 4))
      0: nib = 4'h0;
      1: nib = 4'h4;
      2: nib = 4'h9;
      3: nib = 4'hc;
      default: nib = 4'($urandom);
    endcase
    return {nib, 4'($urandom)};
  endfunction

  task automatic random_episode();
    int               pick;
    c4a50_pkg::kind_e rw;
    pick = $urandom_range(0, 99);
    rw   = c4a50_pkg::kind_e'($urandom_range(0, 1));
    if ($urandom_range(0, 39) == 0) steady_feed = !steady_feed;
    if (pick < 30) begin
      open_gate($urandom_range(0, 4) == 0);
      bus_access(rw, hotspot_addr(), 8'($urandom), 17'($urandom));
    end else if (pick < 45) begin
      bus_access(rw, zero_page_addr(), zero_page_data(), 17'($urandom));
    end else if (pick < 55) begin
      open_gate($urandom_range(0, 4) == 0);
      bus_access(rw, {5'h1f, 8'($urandom)}, 8'($urandom), 17'($urandom));
    end else if (pick < 88) begin
      bus_access(rw, {1'b1, 12'($urandom_range(0, 'heff))}, 8'($urandom), 17'($urandom));
    end else if (pick < 93) begin
      bus_access(c4a50_pkg::KIND_LOAD, 13'($urandom), 8'($urandom), 17'($urandom));
    end else begin
      bus_access(c4a50_pkg::kind_e'($urandom_range(0, 3)), 13'($urandom), 8'($urandom),
                 17'($urandom));
    end
  endtask

  task automatic test_image_load();
    bus_access(c4a50_pkg::KIND_LOAD, 13'h0000, 8'h00, 17'h1ff00);
    bus_access(c4a50_pkg::KIND_LOAD, 13'h1fff, 8'hff, 17'h1ffff);
    bus_access(c4a50_pkg::KIND_LOAD, 13'h0000, 8'h5a, 17'h00000);
    bus_access(c4a50_pkg::KIND_READ, 13'h1f00, 8'hff, 17'h00000);
    bus_access(c4a50_pkg::KIND_READ, 13'h1fff, 8'h00, 17'h1ffff);
    bus_access(c4a50_pkg::KIND_READ, 13'h1000, 8'h00, 17'h00000);
  endtask

  task automatic test_gated_selects();
    // ROM write is dropped but still opens the gate
    bus_access(c4a50_pkg::KIND_WRITE, 13'h1000, 8'h6f, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h0e45, 8'hff, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h1003, 8'h00, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h1003, 8'hff, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h1c00, 8'h7f, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h0f4a, 8'haa, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h1dff, 8'h00, 17'h0);
  endtask

  task automatic test_zero_page_selects();
    bus_access(c4a50_pkg::KIND_WRITE, 13'h0078, 8'h93, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h0074, 8'hff, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h0075, 8'h80, 17'h0);
    // same select again still reports a change
    bus_access(c4a50_pkg::KIND_WRITE, 13'h0075, 8'h80, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h1e00, 8'h77, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h1f38, 8'h00, 17'h0);
  endtask

  task automatic test_low_targets();
    bus_access(c4a50_pkg::KIND_READ, 13'h0080, 8'h12, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h03ff, 8'h81, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h0200, 8'hff, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h0000, 8'hff, 17'h0);
    bus_access(c4a50_pkg::KIND_NONE, 13'h1fff, 8'hff, 17'h1ffff);
  endtask

  task automatic test_locked_hotspots();
    write_lock(1'b1);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h1000, 8'h60, 17'h0);
    bus_access(c4a50_pkg::KIND_READ, 13'h0c12, 8'h34, 17'h0);
    bus_access(c4a50_pkg::KIND_WRITE, 13'h0074, 8'h01, 17'h0);
    write_lock(1'b0);
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int seg = 0; seg < 6; seg++) begin
      write_lock(seg == 3 || $urandom_range(0, 3) == 0);
      goal = items_sent + 300;
      while (items_sent < goal) random_episode();
    end
  endtask

  initial begin
    acc_if.valid     = 1'b0;
    acc_if.kind      = c4a50_pkg::KIND_NONE;
    acc_if.address   = '0;
    acc_if.bus_data  = '0;
    acc_if.rom_index = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    rst_ni           = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_lock(1'b0);
    test_image_load();
    test_gated_selects();
    test_zero_page_selects();
    test_low_targets();
    test_locked_hotspots();
    test_random_traffic();
    finish_traffic();
    repeat (10) @(posedge clk_i);
    if (pending_words.size() != 0) note_mismatch("expected words left over");
    $display("run covered %0d accesses and loads, %0d of them changing the mapping or RAM",
             items_sent, changes_seen);
    $display("%0d result words checked over %0d lock settings, %0d mismatches",
             words_checked, lock_writes, mismatches);
    if (mismatches == 0) begin
      $display("cartridge_4a50_bank_mapper_tb: clean");
    end else begin
      $display("cartridge_4a50_bank_mapper_tb: errors");
    end
    $finish;
  end

endmodule
